// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MSH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("md5sh check failed");

// Next-cycle implication.
`define MSH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("md5sh check failed");

`endif

// ===== hw/rtl/md5sh_pkg.sv =====
// ----------------------------------------------------------------------------
// md5sh_pkg
// Types, constants and round tables for the streaming MD5 block.
// ----------------------------------------------------------------------------
package md5sh_pkg;

  typedef logic [31:0] word_t;

  localparam word_t IV_A = 32'h67452301;
  localparam word_t IV_B = 32'hefcdab89;
  localparam word_t IV_C = 32'h98badcfe;
  localparam word_t IV_D = 32'h10325476;
  localparam word_t [3:0] CHAIN_IV = {IV_D, IV_C, IV_B, IV_A};

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    PAD_NONE,
    PAD_80,
    PAD_ZERO,
    PAD_LEN,
    PAD_DONE
  } pad_e;

  // byte write into the message buffer
  typedef struct packed {
    logic       push;
    logic [5:0] idx;
    logic [7:0] data;
  } buf_wr_t;

  // round unit control
  typedef struct packed {
    logic load;
    logic step;
  } rnd_ctrl_t;

  // message word used by round i
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] t;
    logic [3:0] g;
    t = i[3:0];
    case (i[5:4])
      2'd0:    g = t;
      2'd1:    g = t * 4'd5 + 4'd1;
      2'd2:    g = t * 4'd3 + 4'd5;
      default: g = t * 4'd7;
    endcase
    return g;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic word_t round_const(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/md5_stream_hash.sv =====
// ----------------------------------------------------------------------------
// md5_stream_hash
// Streaming MD5 digest: bytes in, four little-endian digest words out.
// ----------------------------------------------------------------------------
// A byte item is taken while the block is idle. The item that completes a 64-byte block
// holds the input through a setup state (ST_LOAD), 64 rounds in the single
// shared round unit and an add into the chaining words (ST_ADD). An end-of-message item
// then writes the padding and length one byte per cycle (9 to 72 bytes), runs one
// or two more compressions, and presents the digest words A, B, C, D
// one per cycle as the output side takes them. No new item is accepted until
// the fourth word has been transferred.
module md5_stream_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);
  import md5sh_pkg::*;

  state_e      state_q, state_d;
  pad_e        pad_q, pad_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  word_t [3:0] chain_q, chain_d;
  logic [1:0]  oidx_q, oidx_d;

  buf_wr_t     wr;
  rnd_ctrl_t   rctl;
  logic [3:0]  raddr;
  word_t       mword;
  word_t [3:0] rwords;
  logic [5:0]  ridx;
  logic [5:0]  fill_nx;

  md5sh_msgbuf u_msgbuf (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (mword)
  );

  md5sh_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rctl),
    .chain_i (chain_q),
    .m_i     (mword),
    .words_o (rwords),
    .idx_o   (ridx)
  );

  assign fill_nx = fill_q + 6'd1;

  always_comb begin
    state_d   = state_q;
    pad_d     = pad_q;
    bits_d    = bits_q;
    chain_d   = chain_q;
    oidx_d    = oidx_q;
    wr.push   = 1'b0;
    wr.idx    = fill_q;
    wr.data   = data_byte_i;
    rctl.load = 1'b0;
    rctl.step = 1'b0;
    raddr     = msg_index(ridx + 6'd1);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          wr.push = byte_valid_i;
          if (byte_valid_i) begin
            bits_d = bits_q + 64'd8;
          end
          if (end_of_message_i) begin
            pad_d = PAD_80;
          end
          if (byte_valid_i && fill_q == LAST_POS) begin
            state_d = ST_LOAD;
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        wr.push = 1'b1;
        case (pad_q)
          PAD_80: begin
            wr.data = PAD_MARK;
            pad_d   = (fill_nx == LEN_START) ? PAD_LEN : PAD_ZERO;
          end
          PAD_ZERO: begin
            wr.data = 8'h00;
            if (fill_nx == LEN_START) begin
              pad_d = PAD_LEN;
            end
          end
          PAD_LEN: begin
            wr.data = bits_q[{fill_q[2:0], 3'b000} +: 8];
            if (fill_q == LAST_POS) begin
              pad_d = PAD_DONE;
            end
          end
          default: begin
            wr.push = 1'b0;
          end
        endcase
        if (fill_q == LAST_POS) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        rctl.load = 1'b1;
        raddr     = msg_index(6'd0);
        state_d   = ST_ROUND;
      end
      ST_ROUND: begin
        rctl.step = 1'b1;
        if (ridx == LAST_POS) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 4; i++) begin
          chain_d[i] = chain_q[i] + rwords[i];
        end
        if (pad_q == PAD_DONE) begin
          state_d = ST_OUT;
        end else if (pad_q == PAD_NONE) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            chain_d = CHAIN_IV;
            bits_d  = '0;
            pad_d   = PAD_NONE;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign fill_d = wr.push ? fill_nx : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pad_q   <= PAD_NONE;
      fill_q  <= '0;
      bits_q  <= '0;
      chain_q <= CHAIN_IV;
      oidx_q  <= '0;
    end else begin
      state_q <= state_d;
      pad_q   <= pad_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      chain_q <= chain_d;
      oidx_q  <= oidx_d;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = chain_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 2'd3);

endmodule

// ===== hw/rtl/md5sh_msgbuf.sv =====
// ----------------------------------------------------------------------------
// md5sh_msgbuf
// Block buffer: packs bytes little-endian into 16 words, registered read port.
// ----------------------------------------------------------------------------
module md5sh_msgbuf (
  input  logic               clk_i,
  input  md5sh_pkg::buf_wr_t wr_i,
  input  logic [3:0]         raddr_i,
  output md5sh_pkg::word_t   rdata_o
);
  import md5sh_pkg::*;

  word_t       mem [16];
  logic [23:0] asm_q;
  word_t       rdata_q;

  // lower three bytes wait in asm_q, the fourth completes the word
  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      if (wr_i.idx[1:0] == 2'd3) begin
        mem[wr_i.idx[5:2]] <= {wr_i.data, asm_q};
      end else begin
        asm_q[{wr_i.idx[1:0], 3'b000} +: 8] <= wr_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/md5sh_round.sv =====
// ----------------------------------------------------------------------------
// md5sh_round
// Shared round unit: one MD5 round per step on the a/b/c/d working words.
// ----------------------------------------------------------------------------
module md5sh_round (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  md5sh_pkg::rnd_ctrl_t   ctrl_i,
  input  md5sh_pkg::word_t [3:0] chain_i,
  input  md5sh_pkg::word_t       m_i,
  output md5sh_pkg::word_t [3:0] words_o,
  output logic [5:0]             idx_o
);
  import md5sh_pkg::*;

  word_t [3:0] words_q, words_d;
  logic [5:0]  idx_q, idx_d;
  word_t       f, sum, rot;
  logic [4:0]  s;

  always_comb begin
    case (idx_q[5:4])
      2'd0:    f = (words_q[1] & words_q[2]) | (~words_q[1] & words_q[3]);
      2'd1:    f = (words_q[3] & words_q[1]) | (~words_q[3] & words_q[2]);
      2'd2:    f = words_q[1] ^ words_q[2] ^ words_q[3];
      default: f = words_q[2] ^ (words_q[1] | ~words_q[3]);
    endcase
    sum = words_q[0] + f + round_const(idx_q) + m_i;
    s   = rot_amount(idx_q);
    // s is never zero, so the right shift stays below 32
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));

    words_d = words_q;
    idx_d   = idx_q;
    if (ctrl_i.load) begin
      words_d = chain_i;
      idx_d   = '0;
    end else if (ctrl_i.step) begin
      words_d[0] = words_q[3];
      words_d[3] = words_q[2];
      words_d[2] = words_q[1];
      words_d[1] = words_q[1] + rot;
      idx_d      = idx_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= '0;
      idx_q   <= '0;
    end else begin
      words_q <= words_d;
      idx_q   <= idx_d;
    end
  end

  assign words_o = words_q;
  assign idx_o   = idx_q;

endmodule

// ===== hw/rtl/md5sh_checker.sv =====
// ----------------------------------------------------------------------------
// md5sh_checker
// Port-level checks on the MD5 block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module md5sh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        end_of_message_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  word_index_o,
  input logic        last_word_o
);

  // no input transfer while the digest is going out
  `MSH_ASSERT_IMP(a_stall_during_out, out_valid_o, in_stall_o)

  // last marker only on word D
  `MSH_ASSERT_IMP(a_last_on_d, out_valid_o, last_word_o == (word_index_o == 2'd3))

  // digest words follow one another without gaps
  `MSH_ASSERT_NXT(a_words_in_order, out_valid_o && !out_stall_i && !last_word_o, out_valid_o && (word_index_o == $past(word_index_o) + 2'd1))

  // end of message always starts the padding work
  `MSH_ASSERT_NXT(a_end_busy, in_valid_i && !in_stall_o && end_of_message_i, in_stall_o)

endmodule

bind md5_stream_hash md5sh_checker u_md5sh_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .end_of_message_i (end_of_message_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .word_index_o     (word_index_o),
  .last_word_o      (last_word_o)
);

// ===== tb/md5_stream_hash_tb.sv =====
// ----------------------------------------------------------------------------
// md5_stream_hash_tb
// Streams byte messages into the MD5 block and checks every digest word.
// A scoreboard class keeps its own MD5 state, computes the four expected
// words when an end-of-message transfer is taken, and compares each output
// transfer in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module md5_stream_hash_tb;

  localparam int unsigned IDLE_PCT    = 22;
  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no transfer at all
  localparam int unsigned DRAIN_WAIT  = 100;
  localparam int unsigned ITEM_GOAL   = 330;
  localparam int unsigned MSG_GOAL    = 12;

  localparam logic [31:0] CHAIN_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned ROT_BITS [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  index;
    logic        last;
  } digest_word_t;

  class md5_digest_tracker;
    logic [31:0]  chain [4];
    logic [7:0]   block_bytes [64];
    int unsigned  fill;
    logic [63:0]  bit_len;
    digest_word_t digest_q [$];
    int unsigned  errors;
    int unsigned  words_checked;

    function new();
      errors = 0;
      words_checked = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 4; i++) chain[i] = CHAIN_INIT[i];
      fill = 0;
      bit_len = '0;
    endfunction

    function void compress_block();
      logic [31:0] m [16];
      logic [31:0] a, b, c, d, f, sum;
      int unsigned g;
      for (int i = 0; i < 16; i++)
        m[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int i = 0; i < 64; i++) begin
        case (i / 16)
          0: begin
            f = (b & c) | (~b & d);
            g = i;
          end
          1: begin
            f = (d & b) | (~d & c);
            g = (5 * i + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            g = (3 * i + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            g = (7 * i) % 16;
          end
        endcase
        sum = a + f + SINE_K[i] + m[g];
        a = d;
        d = c;
        c = b;
        // shift amounts are 4..23, never zero
        b = b + ((sum << ROT_BITS[(i / 16) * 4 + i % 4]) |
                 (sum >> (32 - ROT_BITS[(i / 16) * 4 + i % 4])));
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    function void push_byte(logic [7:0] v);
      block_bytes[fill] = v;
      fill = (fill + 1) % 64;
      if (fill == 0) compress_block();
    endfunction

    // called for every accepted input transfer
    function void take_item(logic [7:0] data, logic bv, logic eom);
      logic [63:0]  len;
      digest_word_t w;
      if (bv) begin
        push_byte(data);
        bit_len += 64'd8;
      end
      if (!eom) return;
      len = bit_len;
      push_byte(8'h80);
      while (fill != 56) push_byte(8'h00);
      for (int i = 0; i < 8; i++) push_byte(len[8*i +: 8]);
      for (int i = 0; i < 4; i++) begin
        w.value = chain[i];
        w.index = 2'(i);
        w.last  = (i == 3);
        digest_q = {digest_q, w};
      end
      restart();
    endfunction

    function void check_word(logic [31:0] value, logic [1:0] index, logic last);
      digest_word_t want;
      if (digest_q.size() == 0) begin
        errors++;
        $display("%0t: digest word with nothing expected: value %h index %0d last %0b",
                 $time, value, index, last);
        return;
      end
      want = digest_q.pop_front();
      words_checked++;
      if (value !== want.value) begin
        errors++;
        $display("%0t: digest_word expected %h actual %h", $time, want.value, value);
      end
      if (index !== want.index) begin
        errors++;
        $display("%0t: word_index expected %0d actual %0d", $time, want.index, index);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_word expected %0b actual %0b", $time, want.last, last);
      end
    endfunction

    function int unsigned pending();
      return digest_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        byte_valid_i;
  logic        end_of_message_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] digest_word_o;
  logic [1:0]  word_index_o;
  logic        last_word_o;

  md5_digest_tracker tracker = new();

  bit          steady;        // no idling on either side while set
  int unsigned items_sent;    // transfers that carry a byte or an end
  int unsigned ignored_sent;
  int unsigned messages_sent;
  int unsigned quiet_cycles;

  md5_stream_hash dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .byte_valid_i     (byte_valid_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digest_word_o    (digest_word_o),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [7:0] data, input logic bv, input logic eom);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    data_byte_i      <= data;
    byte_valid_i     <= bv;
    end_of_message_i <= eom;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_item(data, bv, eom);
    if (bv || eom) items_sent++;
    else ignored_sent++;
    if (eom) messages_sent++;
    @(negedge clk_i);
  endtask

  // fuse_end puts the end marker on the last byte instead of a bare end item
  task automatic send_message(input int unsigned len, input bit fuse_end, input bit noisy);
    for (int unsigned k = 0; k < len; k++) begin
      if (noisy && $urandom_range(0, 7) == 0)
        send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, fuse_end && (k == len - 1));
    end
    if (!fuse_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_for_digests();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (tracker.pending() != 0);
  endtask

  // output side: stall chosen at the falling edge, transfer checked at the rising edge
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0)
        tracker.check_word(digest_word_o, word_index_o, last_word_o);
    end
  end

  // watchdog: any transfer on either side restarts the count
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned len;
    int unsigned pick;
    int unsigned rand_msgs;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    data_byte_i      = 8'h00;
    byte_valid_i     = 1'b0;
    end_of_message_i = 1'b0;
    steady           = 1'b0;
    items_sent       = 0;
    ignored_sent     = 0;
    messages_sent    = 0;
    rand_msgs        = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty message
    send_item(8'h5a, 1'b0, 1'b1);
    // extremes of the byte, an ignored byte in between, byte and end in one item
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    wait_for_digests();
    // "abc" closed by a bare end item
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    // single byte, end on it, straight after the previous digest
    send_item(8'h7f, 1'b1, 1'b1);

    while (items_sent < ITEM_GOAL || messages_sent < MSG_GOAL) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) len = $urandom_range(0, 20);
      else if (pick < 8) len = $urandom_range(52, 70);   // one or two padding blocks
      else if (pick < 9) len = $urandom_range(110, 130);
      else len = $urandom_range(0, 1);
      steady = (rand_msgs >= 3 && rand_msgs < 6);
      send_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      rand_msgs++;
      if (rand_msgs % 5 == 0) wait_for_digests();
    end
    steady = 1'b0;

    wait_for_digests();
    repeat (DRAIN_WAIT) @(negedge clk_i);

    $display("Covered %0d messages (empty, one byte, block edges, multi-block) from",
             messages_sent);
    $display("%0d data/end transfers and %0d ignored ones; %0d digest words checked.",
             items_sent, ignored_sent, tracker.words_checked);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
